[rtl/plwq_pkg.sv]
package plwq_pkg;

  localparam int NUM_PARTS_DEF   = 16;
  localparam int MAX_WAITERS_DEF = 8;
  localparam int NUM_TXNS_DEF    = 8;
  localparam int STAMP_BITS_DEF  = 48;
  localparam int PEND_MAX        = 31;

  typedef enum logic [2:0] {
    ST_GRANT   = 3'd0,
    ST_WAIT    = 3'd1,
    ST_ABORT   = 3'd2,
    ST_RELEASE = 3'd3,
    ST_REMOVED = 3'd4,
    ST_ERROR   = 3'd5
  } status_t;

  localparam logic OP_LOCK   = 1'b0;
  localparam logic OP_UNLOCK = 1'b1;

  typedef struct packed {
    logic        op;
    logic [3:0]  part_id;
    logic [2:0]  txn_id;
    logic [47:0] stamp;
  } in_word_t;

  typedef struct packed {
    logic [2:0] status;
    logic       promoted_valid;
    logic [2:0] promoted_txn;
    logic       promoted_ready;
    logic [4:0] requester_pending;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture input word, start row read
    logic decide;   // evaluate row, update state, build result
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic busy;
  } dp_sts_t;

endpackage

[rtl/plwq_ctrl.sv]
module plwq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output plwq_pkg::dp_cmd_t cmd
);
  import plwq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_EXEC = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall   = (state_r != S_IDLE);
  assign out_valid  = (state_r == S_OUT);
  assign cmd.load   = (state_r == S_IDLE) && in_valid;
  assign cmd.decide = (state_r == S_EXEC);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_READ;
      S_READ: state_nxt = S_EXEC;
      S_EXEC: state_nxt = S_OUT;
      S_OUT:  if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

[rtl/plwq_dp.sv]
module plwq_dp #(
  parameter int NUM_PARTS   = plwq_pkg::NUM_PARTS_DEF,
  parameter int MAX_WAITERS = plwq_pkg::MAX_WAITERS_DEF,
  parameter int NUM_TXNS    = plwq_pkg::NUM_TXNS_DEF,
  parameter int STAMP_BITS  = plwq_pkg::STAMP_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  plwq_pkg::dp_cmd_t   cmd,
  input  plwq_pkg::in_word_t  in_data,
  output plwq_pkg::out_word_t out_data
);
  import plwq_pkg::*;

  localparam int PW = (NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1;
  localparam int TW = (NUM_TXNS > 1) ? $clog2(NUM_TXNS) : 1;
  localparam int CW = $clog2(MAX_WAITERS + 1);

  typedef struct packed {
    logic [2:0]            txn;
    logic [STAMP_BITS-1:0] stamp;
  } wentry_t;

  // sorted waiter rows, one row per partition, in memory
  wentry_t [MAX_WAITERS-1:0] row_mem [NUM_PARTS];
  wentry_t [MAX_WAITERS-1:0] row_q_r;

  logic [NUM_PARTS-1:0]  held_r;
  logic [2:0]            own_txn_r   [NUM_PARTS];
  logic [STAMP_BITS-1:0] own_stamp_r [NUM_PARTS];
  logic [CW-1:0]         wcnt_r      [NUM_PARTS];
  logic [4:0]            pend_r      [NUM_TXNS];

  logic                  op_r;
  logic [3:0]            part_r;
  logic [2:0]            txn_r;
  logic [STAMP_BITS-1:0] stamp_r;
  logic                  range_ok_r;
  out_word_t             res_r;

  assign out_data = res_r;

  // capture + row read
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r       <= in_data.op;
      part_r     <= in_data.part_id;
      txn_r      <= in_data.txn_id;
      stamp_r    <= STAMP_BITS'(in_data.stamp);
      range_ok_r <= (32'(in_data.part_id) < NUM_PARTS) && (32'(in_data.txn_id) < NUM_TXNS);
      row_q_r    <= row_mem[PW'(in_data.part_id)];
    end
  end

  // decision logic
  logic [PW-1:0]             p;
  logic [TW-1:0]             t;
  logic [CW-1:0]             n;
  logic                      ins_ge [MAX_WAITERS];
  wentry_t [MAX_WAITERS-1:0] ins_row, del_row;
  logic [MAX_WAITERS-1:0]    hit;
  logic [MAX_WAITERS-1:0]    first_hit;
  logic                      any_hit;
  logic [TW-1:0]             w;
  logic [4:0]                pw_dec;
  logic [4:0]                pt_inc, pt_dec;
  logic [2:0]                st;
  logic                      wr_row, do_grant, do_wait, do_rel_free;
  logic                      do_promote, do_remove;
  wentry_t [MAX_WAITERS-1:0] new_row;

  always_comb begin
    p = PW'(part_r);
    t = TW'(txn_r);
    n = wcnt_r[p];
    // insertion: keep entries whose stamp is strictly below new stamp
    for (int i = 0; i < MAX_WAITERS; i++) begin
      ins_ge[i] = (i >= int'(n)) || !(stamp_r > row_q_r[i].stamp);
    end
    for (int i = 0; i < MAX_WAITERS; i++) begin
      if (!ins_ge[i])
        ins_row[i] = row_q_r[i];
      else if (i == 0 || !ins_ge[(i + MAX_WAITERS - 1) % MAX_WAITERS])
        ins_row[i] = '{txn: txn_r, stamp: stamp_r};
      else
        ins_row[i] = row_q_r[(i + MAX_WAITERS - 1) % MAX_WAITERS];
    end
    for (int i = 0; i < MAX_WAITERS; i++) begin
      hit[i] = (i < int'(n)) && (row_q_r[i].txn == txn_r);
    end
    first_hit = hit & (~hit + 1'b1);
    any_hit   = |hit;
    for (int i = 0; i < MAX_WAITERS; i++) begin
      // entries at or after first hit shift down
      if ((first_hit & ((MAX_WAITERS'(1) << i) - 1'b1)) != '0 || first_hit[i])
        del_row[i] = (i + 1 < MAX_WAITERS) ? row_q_r[(i+1) % MAX_WAITERS] : row_q_r[i];
      else
        del_row[i] = row_q_r[i];
    end
    w      = TW'(row_q_r[0].txn);
    pw_dec = (pend_r[w] != 5'd0) ? pend_r[w] - 5'd1 : 5'd0;
    pt_inc = (pend_r[t] != 5'(PEND_MAX)) ? pend_r[t] + 5'd1 : pend_r[t];
    pt_dec = (pend_r[t] != 5'd0) ? pend_r[t] - 5'd1 : 5'd0;

    do_grant = 1'b0; do_wait = 1'b0; do_rel_free = 1'b0;
    do_promote = 1'b0; do_remove = 1'b0;
    st = ST_ERROR;
    if (range_ok_r) begin
      if (op_r == OP_LOCK) begin
        if (!held_r[p]) begin
          do_grant = 1'b1; st = ST_GRANT;
        end else if (!(own_stamp_r[p] < stamp_r)) begin
          st = ST_ABORT;
        end else if (32'(n) >= MAX_WAITERS) begin
          st = ST_ERROR;
        end else begin
          do_wait = 1'b1; st = ST_WAIT;
        end
      end else begin
        if (held_r[p] && own_txn_r[p] == txn_r) begin
          st = ST_RELEASE;
          if (n == '0) do_rel_free = 1'b1;
          else         do_promote  = 1'b1;
        end else if (any_hit) begin
          do_remove = 1'b1; st = ST_REMOVED;
        end
      end
    end
    wr_row  = do_wait || do_promote || do_remove;
    new_row = do_wait ? ins_row : (do_promote ? row_q_r >> (3 + STAMP_BITS) : del_row);
  end

  always_ff @(posedge clk) begin
    if (cmd.decide && wr_row) row_mem[p] <= new_row;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      for (int i = 0; i < NUM_PARTS; i++) begin
        own_txn_r[i]   <= '0;
        own_stamp_r[i] <= '0;
        wcnt_r[i]      <= '0;
      end
      for (int i = 0; i < NUM_TXNS; i++) pend_r[i] <= '0;
    end else if (cmd.decide) begin
      if (do_grant) begin
        held_r[p]      <= 1'b1;
        own_txn_r[p]   <= txn_r;
        own_stamp_r[p] <= stamp_r;
      end
      if (do_rel_free) held_r[p] <= 1'b0;
      if (do_wait) begin
        wcnt_r[p] <= n + 1'b1;
        pend_r[t] <= pt_inc;
      end
      if (do_promote) begin
        own_txn_r[p]   <= 3'(w);
        own_stamp_r[p] <= row_q_r[0].stamp;
        wcnt_r[p]      <= n - 1'b1;
        pend_r[w]      <= pw_dec;
      end
      if (do_remove) begin
        wcnt_r[p] <= n - 1'b1;
        pend_r[t] <= pt_dec;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      res_r.status         <= st;
      res_r.promoted_valid <= do_promote;
      res_r.promoted_txn   <= do_promote ? 3'(w) : 3'd0;
      res_r.promoted_ready <= do_promote && (pw_dec == 5'd0);
      if (!range_ok_r)      res_r.requester_pending <= 5'd0;
      else if (do_wait)     res_r.requester_pending <= pt_inc;
      else if (do_remove)   res_r.requester_pending <= pt_dec;
      else if (do_promote && w == t) res_r.requester_pending <= pw_dec;
      else                  res_r.requester_pending <= pend_r[t];
    end
  end

endmodule

[rtl/partition_lock_wait_queue.sv]
// Steps: capture with row read, a wait state, then decide/write-back into the output
//   register; the result is then held until it is taken.
// A new request is accepted only after the result has been taken; the spacing is set by the
//   read-modify-write of one partition's waiter row in the row memory.
// Reset: synchronous active-low; all partitions free, waiter counts and pending
//   counts cleared. Waiter rows are not cleared (only entries below the count are read).
module partition_lock_wait_queue #(
  parameter int NUM_PARTS   = plwq_pkg::NUM_PARTS_DEF,
  parameter int MAX_WAITERS = plwq_pkg::MAX_WAITERS_DEF,
  parameter int NUM_TXNS    = plwq_pkg::NUM_TXNS_DEF,
  parameter int STAMP_BITS  = plwq_pkg::STAMP_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  plwq_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output plwq_pkg::out_word_t out_data
);
  import plwq_pkg::*;

  dp_cmd_t cmd;

  // controller sequences capture, decide and output hold
  plwq_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .cmd
  );

  // datapath holds lock table, waiter rows and pending counts
  plwq_dp #(
    .NUM_PARTS(NUM_PARTS), .MAX_WAITERS(MAX_WAITERS),
    .NUM_TXNS(NUM_TXNS), .STAMP_BITS(STAMP_BITS)
  ) u_dp (
    .clk, .rst_n, .cmd, .in_data, .out_data
  );

endmodule

[rtl/plwq_chk.sv]
module plwq_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input plwq_pkg::out_word_t out_data
);
  import plwq_pkg::*;

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input open while result pending");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_promo_rel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.promoted_valid |-> out_data.status == ST_RELEASE)
    else $error("promotion without release");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> ##2 out_valid) else $error("result latency");

endmodule

bind partition_lock_wait_queue plwq_chk u_chk (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_data
);

[tb/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import plwq_pkg::*;

  localparam int NPART     = 16;
  localparam int NWAIT     = 8;
  localparam int NTXN      = 8;
  localparam int WDOG_MAX  = 20000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;

  partition_lock_wait_queue u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow lock table: owners, sorted waiter rows, per-transaction pending counts.
  logic        lk_held  [NPART];
  logic [2:0]  lk_txn   [NPART];
  logic [47:0] lk_stamp [NPART];
  logic [2:0]  wt_txn   [NPART][NWAIT];
  logic [47:0] wt_stamp [NPART][NWAIT];
  int          wt_cnt   [NPART];
  int          pend     [NTXN];

  out_word_t expected_words[$];
  int  errors = 0;
  int  idle_cycles = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;

  function automatic void clear_table();
    for (int p = 0; p < NPART; p++) begin
      lk_held[p] = 1'b0;
      lk_txn[p] = '0;
      lk_stamp[p] = '0;
      wt_cnt[p] = 0;
    end
    for (int t = 0; t < NTXN; t++) pend[t] = 0;
  endfunction

  function automatic void drop_entry(int p, int at);
    for (int i = at; i + 1 < wt_cnt[p]; i++) begin
      wt_txn[p][i] = wt_txn[p][i+1];
      wt_stamp[p][i] = wt_stamp[p][i+1];
    end
    wt_cnt[p]--;
  endfunction

  // Applies one request to the shadow table and returns the result word.
  function automatic out_word_t lock_table_step(in_word_t w);
    out_word_t r;
    int p, t, i, pw;
    bit hit;
    r = '0;
    p = w.part_id;
    t = w.txn_id;
    if (w.op == OP_LOCK) begin
      if (!lk_held[p]) begin
        lk_held[p] = 1'b1;
        lk_txn[p] = w.txn_id;
        lk_stamp[p] = w.stamp;
        r.status = ST_GRANT;
      end else if (!(lk_stamp[p] < w.stamp)) begin
        r.status = ST_ABORT;
      end else if (wt_cnt[p] >= NWAIT) begin
        r.status = ST_ERROR;
      end else begin
        // insertion sort; equal stamps let the newcomer go ahead
        i = wt_cnt[p];
        while (i > 0 && !(w.stamp > wt_stamp[p][i-1])) begin
          wt_txn[p][i] = wt_txn[p][i-1];
          wt_stamp[p][i] = wt_stamp[p][i-1];
          i--;
        end
        wt_txn[p][i] = w.txn_id;
        wt_stamp[p][i] = w.stamp;
        wt_cnt[p]++;
        if (pend[t] < PEND_MAX) pend[t]++;
        r.status = ST_WAIT;
      end
    end else if (lk_held[p] && lk_txn[p] == w.txn_id) begin
      r.status = ST_RELEASE;
      if (wt_cnt[p] == 0) begin
        lk_held[p] = 1'b0;
      end else begin
        pw = wt_txn[p][0];
        lk_txn[p] = wt_txn[p][0];
        lk_stamp[p] = wt_stamp[p][0];
        drop_entry(p, 0);
        if (pend[pw] > 0) pend[pw]--;
        r.promoted_valid = 1'b1;
        r.promoted_txn = pw[2:0];
        r.promoted_ready = (pend[pw] == 0);
      end
    end else begin
      hit = 1'b0;
      r.status = ST_ERROR;
      for (i = 0; i < wt_cnt[p] && !hit; i++) begin
        if (wt_txn[p][i] == w.txn_id) begin
          hit = 1'b1;
          drop_entry(p, i);
          if (pend[t] > 0) pend[t]--;
          r.status = ST_REMOVED;
        end
      end
    end
    r.requester_pending = pend[t][4:0];
    return r;
  endfunction

  // Sends one word, predicting its result at acceptance; valid stays high
  // after acceptance so back-to-back words need no second update per edge.
  task automatic send_word(logic op, int part, int txn, logic [47:0] stamp);
    in_word_t w;
    w.op = op;
    w.part_id = part[3:0];
    w.txn_id = txn[2:0];
    w.stamp = stamp;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    expected_words.push_back(lock_table_step(w));
  endtask

  function automatic logic [47:0] rand_stamp();
    return 48'({$urandom, $urandom});
  endfunction

  // receiver stall
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $display("%0t unexpected word: expected none, actual %h", $time, out_data);
        errors++;
      end else begin
        out_word_t e;
        e = expected_words.pop_front();
        if (out_data.status !== e.status)
          $display("%0t status mismatch: expected %0d, actual %0d",
                   $time, e.status, out_data.status);
        if (out_data.promoted_valid !== e.promoted_valid)
          $display("%0t promoted_valid mismatch: expected %0d, actual %0d",
                   $time, e.promoted_valid, out_data.promoted_valid);
        if (out_data.promoted_txn !== e.promoted_txn)
          $display("%0t promoted_txn mismatch: expected %0d, actual %0d",
                   $time, e.promoted_txn, out_data.promoted_txn);
        if (out_data.promoted_ready !== e.promoted_ready)
          $display("%0t promoted_ready mismatch: expected %0d, actual %0d",
                   $time, e.promoted_ready, out_data.promoted_ready);
        if (out_data.requester_pending !== e.requester_pending)
          $display("%0t requester_pending mismatch: expected %0d, actual %0d",
                   $time, e.requester_pending, out_data.requester_pending);
        if (out_data !== e) errors++;
      end
    end
  end

  // watchdog on cycles with no accepted word
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("FAIL partition_lock_wait_queue");
      $finish;
    end
  end

  // Extremes: stamps 0/max, all-ones fields, equal-stamp ordering, full list,
  // unknown unlocker, owner also waiting, self lock.
  task automatic test_directed();
    send_word(OP_UNLOCK, 0, 0, 0);                 // unlock on free partition
    send_word(OP_LOCK, 15, 7, 48'd100);            // grant
    send_word(OP_LOCK, 15, 7, 48'd100);            // own partition, equal stamp: abort
    send_word(OP_LOCK, 15, 7, 48'd101);            // own partition, younger: wait
    for (int i = 0; i < 7; i++)
      send_word(OP_LOCK, 15, i, (i < 3) ? 48'd200 : 48'hFFFF_FFFF_FFFF);
    send_word(OP_LOCK, 15, 1, 48'd300);            // list full: error
    send_word(OP_LOCK, 15, 2, 48'd0);              // older: abort
    send_word(OP_UNLOCK, 15, 3, 0);                // waiter removes itself
    send_word(OP_UNLOCK, 15, 3, 0);                // no longer listed: error
    send_word(OP_UNLOCK, 3, 5, 0);                 // unknown unlocker
    for (int i = 0; i < 7; i++) send_word(OP_UNLOCK, 15, 7, 0);  // two hand-offs, then errors once txn 7 no longer owns
    send_word(OP_UNLOCK, 15, 7, 0);
    send_word(OP_UNLOCK, 15, 0, 0);
  endtask

  // Mostly well-formed lock/unlock traffic on a few partitions, some noise.
  task automatic test_random(int count);
    int p, t;
    for (int n = 0; n < count; n++) begin
      p = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(3);
      t = $urandom_range(7);
      if ($urandom_range(9) == 0)
        send_word(1'($urandom_range(1)), p, t, rand_stamp());
      else if ($urandom_range(1))
        send_word(OP_LOCK, p, t, {44'd0, t[2:0], 1'b0} + 48'($urandom_range(3)));
      else if (lk_held[p] && $urandom_range(1))
        send_word(OP_UNLOCK, p, lk_txn[p], rand_stamp());
      else if (wt_cnt[p] > 0)
        send_word(OP_UNLOCK, p, wt_txn[p][$urandom_range(wt_cnt[p]-1)], rand_stamp());
      else
        send_word(OP_UNLOCK, p, t, rand_stamp());
    end
  endtask

  initial begin
    clear_table();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    send_idle_pct = 32; recv_idle_pct = 86;
    test_random(350);
    send_idle_pct = 86; recv_idle_pct = 32;
    test_random(350);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(350);
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("PASS partition_lock_wait_queue");
    else $display("FAIL partition_lock_wait_queue");
    $finish;
  end

endmodule
